[hw/rtl/text_console_cell_writer_core_assert.svh]
// assertion macros for the checker file
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tccw_pkg.sv]
// -----------------------------------------------------------------------------
// tccw_pkg
// Types, codes and default sizes for the text console cell writer.
// -----------------------------------------------------------------------------
package tccw_pkg;

  localparam int unsigned DefColumns   = 80;
  localparam int unsigned DefRows      = 25;
  localparam int unsigned DefTabSpaces = 4;

  localparam int unsigned CharCodeW = 8;
  localparam int unsigned CellAddrW = 11;
  localparam int unsigned CellCodeW = 7;
  localparam int unsigned ColorW    = 8;

  localparam int unsigned QueueDepth = 2;

  localparam logic [CharCodeW-1:0] CharNewline   = 8'h0A;
  localparam logic [CharCodeW-1:0] CharTab       = 8'h09;
  localparam logic [CellCodeW-1:0] CellCodeSpace = 7'h20;
  localparam logic [ColorW-1:0]    ColorReset    = 8'h0A;

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_TAB,
    OP_NEWLINE
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [CellCodeW-1:0]   code;
  } op_t;

endpackage

[hw/rtl/tccw_char_if.sv]
// -----------------------------------------------------------------------------
// tccw_char_if
// Character byte channel: valid, ready and one character code.
// -----------------------------------------------------------------------------
interface tccw_char_if
  import tccw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CharCodeW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

[hw/rtl/tccw_cell_if.sv]
// -----------------------------------------------------------------------------
// tccw_cell_if
// Cell write channel: valid, ready and one text memory cell write.
// -----------------------------------------------------------------------------
interface tccw_cell_if
  import tccw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CellAddrW-1:0] cell_address;
  logic [CellCodeW-1:0] cell_code;
  logic [ColorW-1:0]    cell_color;
  logic                 last_write;

  modport source (
    output valid, output cell_address, output cell_code, output cell_color,
    output last_write, input ready
  );
  modport sink (
    input valid, input cell_address, input cell_code, input cell_color,
    input last_write, output ready
  );
endinterface

[hw/rtl/tccw_front.sv]
// -----------------------------------------------------------------------------
// tccw_front
// Accepts character beats and sorts them into print, tab and newline ops.
// -----------------------------------------------------------------------------
module tccw_front
  import tccw_pkg::*;
(
  tccw_char_if.sink char_i,
  input  logic      q_full_i,
  output logic      push_o,
  output op_t       push_op_o
);

  logic keep;

  always_comb begin
    push_op_o.kind = OP_PRINT;
    push_op_o.code = char_i.char_code[CellCodeW-1:0];
    keep           = 1'b0;
    if (char_i.char_code == CharNewline) begin
      push_op_o.kind = OP_NEWLINE;
      keep           = 1'b1;
    end else if (char_i.char_code == CharTab) begin
      push_op_o.kind = OP_TAB;
      keep           = 1'b1;
    end else if (!char_i.char_code[7] && (char_i.char_code[6:5] != 2'b00)) begin
      // 0x20 to 0x7f
      keep = 1'b1;
    end
  end

  // ignored bytes are taken and dropped
  assign char_i.ready = !q_full_i;
  assign push_o       = char_i.valid && !q_full_i && keep;

endmodule

[hw/rtl/tccw_op_queue.sv]
// -----------------------------------------------------------------------------
// tccw_op_queue
// Short register queue of classified ops between the front and back ends.
// -----------------------------------------------------------------------------
module tccw_op_queue
  import tccw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output op_t  head_op_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_op_o    = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

[hw/rtl/tccw_back.sv]
// -----------------------------------------------------------------------------
// tccw_back
// Carries out queued ops: keeps the cursor and drives the cell write register.
// -----------------------------------------------------------------------------
module tccw_back
  import tccw_pkg::*;
#(
  parameter int unsigned COLUMNS    = DefColumns,
  parameter int unsigned ROWS       = DefRows,
  parameter int unsigned TAB_SPACES = DefTabSpaces
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              text_color_we_i,
  input  logic [ColorW-1:0] text_color_i,
  input  logic              head_valid_i,
  input  op_t               head_op_i,
  output logic              pop_o,
  tccw_cell_if.source       cell_o
);

  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned AddrW = $clog2(COLUMNS * ROWS);
  localparam int unsigned TabW  = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [AddrW-1:0]     base_q, base_d;
  logic [TabW-1:0]      tab_cnt_q, tab_cnt_d;
  logic [ColorW-1:0]    color_q;

  logic                 out_valid_q;
  logic [CellAddrW-1:0] out_addr_q;
  logic [CellCodeW-1:0] out_code_q;
  logic [ColorW-1:0]    out_color_q;
  logic                 out_last_q;

  logic out_free, fire, emit, last_beat, next_row;
  logic [AddrW-1:0]     cur_addr;
  logic [CellCodeW-1:0] cur_code;

  assign out_free  = !out_valid_q || cell_o.ready;
  assign fire      = head_valid_i && ((head_op_i.kind == OP_NEWLINE) || out_free);
  assign emit      = fire && (head_op_i.kind != OP_NEWLINE);
  assign last_beat = (head_op_i.kind != OP_TAB) || (tab_cnt_q == TabW'(TAB_SPACES - 1));
  assign pop_o     = fire && last_beat;
  assign cur_addr  = base_q + AddrW'(col_q);
  assign cur_code  = (head_op_i.kind == OP_TAB) ? CellCodeSpace : head_op_i.code;

  // a newline, or a write in the last column, moves to the next row
  assign next_row = fire && ((head_op_i.kind == OP_NEWLINE) ||
                             (col_q == ColW'(COLUMNS - 1)));

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    base_d    = base_q;
    tab_cnt_d = tab_cnt_q;
    if (next_row) begin
      col_d = '0;
      if (row_q == RowW'(ROWS - 1)) begin
        row_d  = '0;
        base_d = '0;
      end else begin
        row_d  = row_q + 1'b1;
        base_d = base_q + AddrW'(COLUMNS);
      end
    end else if (emit) begin
      col_d = col_q + 1'b1;
    end
    if (emit && (head_op_i.kind == OP_TAB)) begin
      tab_cnt_d = last_beat ? '0 : tab_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      tab_cnt_q   <= '0;
      color_q     <= ColorReset;
      out_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      base_q    <= base_d;
      tab_cnt_q <= tab_cnt_d;
      if (text_color_we_i) begin
        color_q <= text_color_i;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_addr_q  <= CellAddrW'(cur_addr);
      out_code_q  <= cur_code;
      out_color_q <= color_q;
      out_last_q  <= last_beat;
    end
  end

  assign cell_o.valid        = out_valid_q;
  assign cell_o.cell_address = out_addr_q;
  assign cell_o.cell_code    = out_code_q;
  assign cell_o.cell_color   = out_color_q;
  assign cell_o.last_write   = out_last_q;

endmodule

[hw/rtl/text_console_cell_writer_core.sv]
// -----------------------------------------------------------------------------
// text_console_cell_writer_core
// Character stream to text screen cell writes with a wrapping cursor.
// -----------------------------------------------------------------------------
// Takes one character byte per cycle. A printable byte (0x20 to 0x7f) gives
// one cell write beat, a tab gives TAB_SPACES space beats, a newline moves the
// cursor and gives none, and every other byte is dropped. The cursor wraps at
// the last column and the last row; there is no scrolling. The first beat of
// an item is held first in the op queue and then in the cell write register.
// The back end turns out one cell write per cycle while the sink is ready, so
// a tab holds it for all of its beats; a two-entry op queue keeps the input
// taking bytes during that time and stalls it only once the queue is full.
// text_color is sampled as each beat is formed.
module text_console_cell_writer_core
  import tccw_pkg::*;
#(
  parameter int unsigned COLUMNS    = DefColumns,
  parameter int unsigned ROWS       = DefRows,
  parameter int unsigned TAB_SPACES = DefTabSpaces
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              text_color_we_i,
  input  logic [ColorW-1:0] text_color_i,
  tccw_char_if.sink         char_i,
  tccw_cell_if.source       cell_o
);

  logic push, q_full, head_valid, pop;
  op_t  push_op, head_op;

  tccw_front u_front (
    .char_i    (char_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .push_op_o (push_op)
  );

  tccw_op_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_op_i    (push_op),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_op_o    (head_op)
  );

  tccw_back #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .text_color_we_i (text_color_we_i),
    .text_color_i    (text_color_i),
    .head_valid_i    (head_valid),
    .head_op_i       (head_op),
    .pop_o           (pop),
    .cell_o          (cell_o)
  );

endmodule

[hw/rtl/tccw_checker.sv]
// -----------------------------------------------------------------------------
// tccw_checker
// Port-level checks on the cell write stream of the cell writer core.
// -----------------------------------------------------------------------------
`include "text_console_cell_writer_core_assert.svh"

module tccw_checker
  import tccw_pkg::*;
#(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cell_valid_i,
  input logic                 cell_ready_i,
  input logic [CellAddrW-1:0] cell_address_i,
  input logic [CellCodeW-1:0] cell_code_i,
  input logic [ColorW-1:0]    cell_color_i,
  input logic                 last_write_i
);

  // a stalled beat stays and holds its payload
  `TCCW_ASSERT_NEXT(a_out_hold, cell_valid_i && !cell_ready_i, cell_valid_i && $stable(cell_address_i) && $stable(cell_code_i) && $stable(cell_color_i) && $stable(last_write_i), "cell beat dropped or changed while stalled")

  // only a tab gives more than one beat, and those are spaces
  `TCCW_ASSERT_NOW(a_mid_is_space, cell_valid_i && !last_write_i, cell_code_i == CellCodeSpace, "non-final beat is not a space")

  // address stays on the screen
  `TCCW_ASSERT_NOW(a_addr_range, cell_valid_i, (COLUMNS * ROWS > 2048) || (int'(cell_address_i) < COLUMNS * ROWS), "cell address off screen")

  // every code written is printable
  `TCCW_ASSERT_NOW(a_code_print, cell_valid_i, cell_code_i >= CellCodeSpace, "control code written to a cell")

endmodule

bind text_console_cell_writer_core tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cell_valid_i   (cell_o.valid),
  .cell_ready_i   (cell_o.ready),
  .cell_address_i (cell_o.cell_address),
  .cell_code_i    (cell_o.cell_code),
  .cell_color_i   (cell_o.cell_color),
  .last_write_i   (cell_o.last_write)
);
